// ===== src/assert_macros.svh =====
// Assertion macros for the RTL; the top-level file includes them. Synthesis builds define SYNTH,
// which turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on the rising clock edge, off while reset is held.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");

// Checks that a condition never holds on a rising clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== src/bcrs_pkg.sv =====
package bcrs_pkg;

    // Fixed point format of the operands and of the root.
    localparam int X_W   = 24;
    localparam int F_B   = 16;
    localparam int TOL_W = 24;
    localparam int STAT_W = 2;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = ((3 * X_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((X_W + 7) / 8) * 8;

    // Exact widths of the cubic evaluation.
    // t1 = x - 2, t2 = t1*x - 5, acc = t2*x + (6 - c), all scaled.
    localparam int T1_W  = ((X_W > F_B + 2) ? X_W : F_B + 2) + 1;
    localparam int P_W   = T1_W + X_W;
    localparam int T2_W  = ((P_W > 2 * F_B + 4) ? P_W : 2 * F_B + 4) + 1;
    localparam int LO_W  = X_W;
    localparam int HI_W  = T2_W - LO_W;
    localparam int MA0_W = (T1_W > LO_W + 1) ? T1_W : LO_W + 1;
    localparam int MA_W  = (MA0_W > HI_W) ? MA0_W : HI_W;
    localparam int MP_W  = MA_W + X_W;
    localparam int K_W   = ((X_W > F_B + 4) ? X_W : F_B + 4) + 1;
    localparam int ACC_W = ((T2_W + X_W > K_W + 2 * F_B) ?
                            T2_W + X_W : K_W + 2 * F_B) + 1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOBR = 2'd2;

    // Operand select for a new evaluation.
    localparam logic XS_LO = 1'b0;
    localparam logic XS_HI = 1'b1;

    // Evaluation steps on the shared multiplier.
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_MUL1 = 3'd1;
    localparam logic [2:0] EV_SUB  = 3'd2;
    localparam logic [2:0] EV_LO   = 3'd3;
    localparam logic [2:0] EV_HI   = 3'd4;

    // Root source for the result.
    localparam logic [1:0] RS_ZERO = 2'd0;
    localparam logic [1:0] RS_LO   = 2'd1;
    localparam logic [1:0] RS_HI   = 2'd2;
    localparam logic [1:0] RS_MID  = 2'd3;

    typedef struct packed {
        logic              load_in;
        logic              x_load;
        logic              x_sel;
        logic              mid_load;
        logic [2:0]        ev_step;
        logic              save_a;
        logic              bisect;
        logic              out_load;
        logic [1:0]        res_sel;
        logic [STAT_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic f_neg;
        logic f_zero;
        logic a_neg;
        logic a_zero;
        logic narrow;
    } sts_t;

endpackage

// ===== src/bcrs_dp.sv =====
module bcrs_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bcrs_pkg::TOL_W-1:0]          cfg_wdata,
    input  logic [bcrs_pkg::S_TDATA_W-1:0]      in_data,
    input  bcrs_pkg::cmd_t                      cmd,
    output bcrs_pkg::sts_t                      sts,
    output logic signed [bcrs_pkg::X_W-1:0]     root_out,
    output logic [bcrs_pkg::STAT_W-1:0]         status_out
);

    localparam int X_W   = bcrs_pkg::X_W;
    localparam int F_B   = bcrs_pkg::F_B;
    localparam int T1_W  = bcrs_pkg::T1_W;
    localparam int P_W   = bcrs_pkg::P_W;
    localparam int T2_W  = bcrs_pkg::T2_W;
    localparam int LO_W  = bcrs_pkg::LO_W;
    localparam int MA_W  = bcrs_pkg::MA_W;
    localparam int MP_W  = bcrs_pkg::MP_W;
    localparam int K_W   = bcrs_pkg::K_W;
    localparam int ACC_W = bcrs_pkg::ACC_W;
    localparam int TOL_W = bcrs_pkg::TOL_W;
    localparam int CMP_W = (X_W + 1 > TOL_W) ? X_W + 1 : TOL_W;

    localparam logic signed [T1_W-1:0] TWO_S  = T1_W'(2) << F_B;
    localparam logic signed [T2_W-1:0] FIVE_S = T2_W'(5) << (2 * F_B);
    localparam logic signed [K_W-1:0]  SIX_S  = K_W'(6) << F_B;

    logic signed [X_W-1:0]   c_reg;
    logic signed [X_W-1:0]   lo_reg;
    logic signed [X_W-1:0]   hi_reg;
    logic signed [X_W-1:0]   mid_reg;
    logic signed [X_W-1:0]   x_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic signed [P_W-1:0]   p_reg;
    logic signed [T2_W-1:0]  t2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    a_neg_reg;
    logic                    a_zero_reg;
    logic signed [X_W-1:0]   root_reg;
    logic [bcrs_pkg::STAT_W-1:0] status_reg;

    logic signed [T1_W-1:0]  t1;
    logic signed [MA_W-1:0]  ma;
    logic signed [MP_W-1:0]  prod;
    logic signed [K_W-1:0]   k_term;
    logic signed [X_W:0]     bound_sum;
    logic signed [X_W-1:0]   mid_next;
    logic signed [X_W:0]     width_s;
    logic [TOL_W-1:0]        tol_eff;
    logic signed [X_W-1:0]   root_sel;

    assign t1     = T1_W'(x_reg) - TWO_S;
    assign k_term = SIX_S - K_W'(c_reg);

    // One shared signed multiplier; t2 is split into an unsigned low part
    // and a signed high part so the operand stays narrow.
    always_comb begin
        case (cmd.ev_step)
            bcrs_pkg::EV_MUL1: ma = MA_W'(t1);
            bcrs_pkg::EV_LO:   ma = MA_W'(signed'({1'b0, t2_reg[LO_W-1:0]}));
            bcrs_pkg::EV_HI:   ma = MA_W'(signed'(t2_reg[T2_W-1:LO_W]));
            default:           ma = '0;
        endcase
    end

    assign prod = ma * x_reg;

    assign bound_sum = (X_W + 1)'(lo_reg) + (X_W + 1)'(hi_reg);
    assign mid_next  = X_W'(bound_sum >>> 1);
    assign width_s   = (X_W + 1)'(hi_reg) - (X_W + 1)'(lo_reg);
    assign tol_eff   = (tol_reg == '0) ? TOL_W'(1) : tol_reg;

    always_comb begin
        case (cmd.res_sel)
            bcrs_pkg::RS_LO:  root_sel = lo_reg;
            bcrs_pkg::RS_HI:  root_sel = hi_reg;
            bcrs_pkg::RS_MID: root_sel = mid_reg;
            default:          root_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_W'(1);
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            c_reg  <= in_data[X_W-1:0];
            lo_reg <= in_data[2*X_W-1:X_W];
            hi_reg <= in_data[3*X_W-1:2*X_W];
        end else if (cmd.bisect) begin
            if (acc_reg[ACC_W-1] != a_neg_reg) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg;
            end
        end

        if (cmd.mid_load) begin
            mid_reg <= mid_next;
            x_reg   <= mid_next;
        end else if (cmd.x_load) begin
            x_reg <= (cmd.x_sel == bcrs_pkg::XS_HI) ? hi_reg : lo_reg;
        end

        case (cmd.ev_step)
            bcrs_pkg::EV_MUL1: p_reg   <= P_W'(prod);
            bcrs_pkg::EV_SUB:  t2_reg  <= T2_W'(p_reg) - FIVE_S;
            bcrs_pkg::EV_LO:   acc_reg <= ACC_W'(prod) + (ACC_W'(k_term) <<< (2 * F_B));
            bcrs_pkg::EV_HI:   acc_reg <= acc_reg + (ACC_W'(prod) <<< LO_W);
            default: begin
            end
        endcase

        if (cmd.save_a) begin
            a_neg_reg  <= acc_reg[ACC_W-1];
            a_zero_reg <= (acc_reg == '0);
        end

        if (cmd.out_load) begin
            root_reg   <= root_sel;
            status_reg <= cmd.res_status;
        end
    end

    assign sts.bad    = (lo_reg >= hi_reg);
    assign sts.f_neg  = acc_reg[ACC_W-1];
    assign sts.f_zero = (acc_reg == '0);
    assign sts.a_neg  = a_neg_reg;
    assign sts.a_zero = a_zero_reg;
    assign sts.narrow = (CMP_W'($unsigned(width_s)) <= CMP_W'(tol_eff));

    assign root_out   = root_reg;
    assign status_out = status_reg;

endmodule

// ===== src/bcrs_ctrl.sv =====
module bcrs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  bcrs_pkg::sts_t sts,
    output bcrs_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_SUB   = 4'd3;
    localparam logic [3:0] S_MLO   = 4'd4;
    localparam logic [3:0] S_MHI   = 4'd5;
    localparam logic [3:0] S_JUDGE = 4'd6;
    localparam logic [3:0] S_MID   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_M = 2'd2;

    logic [3:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [1:0]                  res_sel_reg, res_sel_next;
    logic [bcrs_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic                        m_valid_reg, m_valid_next;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        phase_next      = phase_reg;
        res_sel_next    = res_sel_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad) begin
                    res_sel_next    = bcrs_pkg::RS_ZERO;
                    res_status_next = bcrs_pkg::ST_BAD;
                    state_next      = S_OUT;
                end else begin
                    cmd.x_load = 1'b1;
                    cmd.x_sel  = bcrs_pkg::XS_LO;
                    phase_next = PH_A;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.ev_step = bcrs_pkg::EV_MUL1;
                state_next  = S_SUB;
            end
            S_SUB: begin
                cmd.ev_step = bcrs_pkg::EV_SUB;
                state_next  = S_MLO;
            end
            S_MLO: begin
                cmd.ev_step = bcrs_pkg::EV_LO;
                state_next  = S_MHI;
            end
            S_MHI: begin
                cmd.ev_step = bcrs_pkg::EV_HI;
                state_next  = S_JUDGE;
            end
            S_JUDGE: begin
                case (phase_reg)
                    PH_A: begin
                        cmd.save_a = 1'b1;
                        cmd.x_load = 1'b1;
                        cmd.x_sel  = bcrs_pkg::XS_HI;
                        phase_next = PH_B;
                        state_next = S_MUL1;
                    end
                    PH_B: begin
                        if (sts.a_zero) begin
                            res_sel_next    = bcrs_pkg::RS_LO;
                            res_status_next = bcrs_pkg::ST_OK;
                            state_next      = S_OUT;
                        end else if (sts.f_zero) begin
                            res_sel_next    = bcrs_pkg::RS_HI;
                            res_status_next = bcrs_pkg::ST_OK;
                            state_next      = S_OUT;
                        end else if (sts.f_neg == sts.a_neg) begin
                            res_sel_next    = bcrs_pkg::RS_ZERO;
                            res_status_next = bcrs_pkg::ST_NOBR;
                            state_next      = S_OUT;
                        end else begin
                            cmd.mid_load = 1'b1;
                            phase_next   = PH_M;
                            state_next   = S_MUL1;
                        end
                    end
                    default: begin
                        if (sts.narrow || sts.f_zero) begin
                            res_sel_next    = bcrs_pkg::RS_MID;
                            res_status_next = bcrs_pkg::ST_OK;
                            state_next      = S_OUT;
                        end else begin
                            cmd.bisect = 1'b1;
                            state_next = S_MID;
                        end
                    end
                endcase
            end
            S_MID: begin
                cmd.mid_load = 1'b1;
                state_next   = S_MUL1;
            end
            S_OUT: begin
                cmd.res_sel    = res_sel_reg;
                cmd.res_status = res_status_reg;
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_A;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_sel_reg    <= res_sel_next;
        res_status_reg <= res_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== src/bisection_cubic_root_solver.sv =====
// Bisection root finder for f(x) = x^3 - 2x^2 - 5x + 6 - c. Each request
// carries an offset c and an interval [a, b] in signed Q8.16; the block
// answers with one result: a root estimate and a status (0 root found,
// 1 bad interval because a >= b, 2 no sign change between the ends). The
// cubic is evaluated exactly in a 75-bit accumulator and only its sign and
// zero test are used, so there is no rounding anywhere. An endpoint where
// f is zero is returned as is; otherwise the interval is halved with a
// floored midpoint until its width in LSBs is at or below the tolerance
// register (a tolerance of zero acts as one) or f at the midpoint is
// zero, and that midpoint is returned. The root reads zero whenever the
// status is not 0. One request is worked at a time. Every evaluation of f
// uses a single shared 26x24 signed multiplier three times, which sets the
// pace. A bad interval is answered without evaluating f, an end root or a
// missing bracket after f at both ends; otherwise f is also evaluated at
// each midpoint, and with unit tolerance over a wide interval near 24
// halvings follow the first one. A finished result waits in the output
// register, so the next request is taken while it is still unread. The
// tolerance is written through cfg_we and cfg_wdata; the user must write
// it only while the block is idle, and the block itself does not enforce it.
`include "assert_macros.svh"

module bisection_cubic_root_solver (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Tolerance register write.
    input  logic                               cfg_we,
    input  logic [bcrs_pkg::TOL_W-1:0]         cfg_wdata,

    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0 up: offset_c[23:0], left_end[47:24], right_end[71:48].
    input  logic [bcrs_pkg::S_TDATA_W-1:0]     s_tdata,

    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0 up: root[23:0].
    output logic [bcrs_pkg::M_TDATA_W-1:0]     m_tdata,
    // From bit 0 up: status[1:0].
    output logic [bcrs_pkg::STAT_W-1:0]        m_tuser
);

    bcrs_pkg::cmd_t                  ctl_cmd;
    bcrs_pkg::sts_t                  dp_sts;
    logic signed [bcrs_pkg::X_W-1:0] root_out;
    logic [bcrs_pkg::STAT_W-1:0]     status_out;

    // The controller sequences the endpoint checks and halving steps.
    bcrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    // The datapath holds the interval, evaluates the cubic and keeps the
    // output register.
    bcrs_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_tdata),
        .cmd        (ctl_cmd),
        .sts        (dp_sts),
        .root_out   (root_out),
        .status_out (status_out)
    );

    assign m_tdata = bcrs_pkg::M_TDATA_W'($unsigned(root_out));
    assign m_tuser = status_out;

    // A result that reports a failure must carry a zero root.
    `ASSERT_PROP(a_fail_root_zero, aclk, aresetn, (m_tvalid && m_tuser != bcrs_pkg::ST_OK) |-> (m_tdata == '0))
    // The output register is never reloaded while a result still waits.
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, ctl_cmd.out_load && m_tvalid && !m_tready)
    // Midpoints are only taken from a properly ordered interval.
    `ASSERT_PROP(a_ordered_bracket, aclk, aresetn, ctl_cmd.mid_load |-> !dp_sts.bad)
    // Once a request is taken the block is busy in the next cycle.
    `ASSERT_PROP(a_busy_after_take, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

endmodule
